[rtl/core/sorted_record_table_assert.svh]
// Assertion macros used by the RTL of the sorted record table.
`ifndef SORTED_RECORD_TABLE_ASSERT_SVH
`define SORTED_RECORD_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_record_table: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_record_table: next-cycle check failed");

`endif

[rtl/core/srt_pkg.sv]
package srt_pkg;

  // Default table depth
  localparam int CAPACITY_DEF = 16;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_PUT,
    S_FND_CHK,
    S_DONE
  } state_t;

  // One stored record
  typedef struct packed {
    logic [15:0] id;
    logic [11:0] age;
  } rec_t;

endpackage

[rtl/core/srt_in_if.sv]
interface srt_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] key_id;
  logic [11:0] entry_age;

  modport source (output valid, output func, output key_id, output entry_age, input ready);
  modport sink   (input valid, input func, input key_id, input entry_age, output ready);
endinterface

[rtl/core/srt_out_if.sv]
interface srt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] found_age;
  logic [3:0]  position;
  logic [4:0]  count_now;

  modport source (output valid, output status, output found_age, output position,
                  output count_now, input ready);
  modport sink   (input valid, input status, input found_age, input position,
                  input count_now, output ready);
endinterface

[rtl/core/sorted_record_table.sv]
// Sorted record table: holds up to CAPACITY (id, age) records, largest age first.
// in_ch carries one word per operation: func selects insert or find, key_id is the
// record id, entry_age the ordering key (unused on find). out_ch returns one word
// per operation: status, found_age, position and count_now.
// The records sit in a single-port-write, single-port-read memory with registered
// read data; one record is examined per cycle by a small sequencer.
// An insert into a non-empty table walks backward from the last record, shifting each
// record with a smaller age up one slot, then writes the new record in the freed slot;
// an insert into an empty table writes slot 0 at once. A find walks forward from slot 0
// until the id matches (status OK, with its age and position) or the last record is
// checked without a match (NOTFOUND). A full insert or a find on an empty table goes
// straight to its result. The sequencer returns to idle as the result loads.
// in_ch.ready is high only while the sequencer is idle; one operation runs at a time.
// The result waits in an output register; the next word is accepted while it waits,
// and the sequencer holds its finished result until out_ch.ready frees that register.
// Reset (rst_n low, synchronous) empties the table and drops any pending result;
// no clearing pass runs, stale memory is never read past the record count.
`include "sorted_record_table_assert.svh"

module sorted_record_table #(
  parameter int CAPACITY = srt_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  srt_in_if.sink            in_ch,
  srt_out_if.source         out_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  srt_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [15:0]      key_r, key_nxt;
  logic [11:0]      age_r, age_nxt;
  srt_pkg::status_t res_status_r, res_status_nxt;
  logic [11:0]      res_age_r, res_age_nxt;
  logic [AW-1:0]    res_pos_r, res_pos_nxt;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [11:0]      out_age_r;
  logic [3:0]       out_pos_r;
  logic [4:0]       out_count_r;

  srt_pkg::rec_t    mem_r [CAPACITY];
  srt_pkg::rec_t    rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  srt_pkg::rec_t    wr_data;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             is_full;
  logic             is_empty;
  logic [AW-1:0]    last_addr;

  assign in_ch.ready = (state_r == srt_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign is_full     = (count_r == CW'(CAPACITY));
  assign is_empty    = (count_r == '0);
  assign last_addr   = AW'(count_r - 1'b1);

  // Sequencer: next state, memory access and result
  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    age_nxt        = age_r;
    res_status_nxt = res_status_r;
    res_age_nxt    = res_age_r;
    res_pos_nxt    = res_pos_r;
    rd_en          = 1'b0;
    rd_addr        = ptr_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r + 1'b1;
    wr_data        = rd_data_r;
    out_load       = 1'b0;
    unique case (state_r)
      srt_pkg::S_IDLE: begin
        if (in_acc) begin
          key_nxt        = in_ch.key_id;
          age_nxt        = in_ch.entry_age;
          res_age_nxt    = '0;
          res_pos_nxt    = '0;
          res_status_nxt = srt_pkg::ST_OK;
          if (in_ch.func == srt_pkg::FUNC_INSERT) begin
            priority if (is_full) begin
              res_status_nxt = srt_pkg::ST_FULL;
              state_nxt      = srt_pkg::S_DONE;
            end else if (is_empty) begin
              ptr_nxt   = '0;
              state_nxt = srt_pkg::S_INS_PUT;
            end else begin
              // start the backward walk at the last record
              rd_en     = 1'b1;
              rd_addr   = last_addr;
              ptr_nxt   = last_addr;
              state_nxt = srt_pkg::S_INS_CHK;
            end
          end else begin
            if (is_empty) begin
              res_status_nxt = srt_pkg::ST_NOTFOUND;
              state_nxt      = srt_pkg::S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              ptr_nxt   = '0;
              state_nxt = srt_pkg::S_FND_CHK;
            end
          end
        end
      end
      srt_pkg::S_INS_CHK: begin
        if (age_r > rd_data_r.age) begin
          // shift the smaller record up one slot, fetch the one before it
          wr_en   = 1'b1;
          wr_addr = ptr_r + 1'b1;
          wr_data = rd_data_r;
          if (ptr_r == '0) begin
            state_nxt = srt_pkg::S_INS_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_r - 1'b1;
            ptr_nxt = ptr_r - 1'b1;
          end
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = srt_pkg::S_INS_PUT;
        end
      end
      srt_pkg::S_INS_PUT: begin
        wr_en          = 1'b1;
        wr_addr        = ptr_r;
        wr_data        = '{id: key_r, age: age_r};
        count_nxt      = count_r + 1'b1;
        res_status_nxt = srt_pkg::ST_OK;
        res_pos_nxt    = ptr_r;
        state_nxt      = srt_pkg::S_DONE;
      end
      srt_pkg::S_FND_CHK: begin
        priority if (rd_data_r.id == key_r) begin
          res_status_nxt = srt_pkg::ST_OK;
          res_age_nxt    = rd_data_r.age;
          res_pos_nxt    = ptr_r;
          state_nxt      = srt_pkg::S_DONE;
        end else if (ptr_r == last_addr) begin
          res_status_nxt = srt_pkg::ST_NOTFOUND;
          state_nxt      = srt_pkg::S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + 1'b1;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      srt_pkg::S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = srt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    key_r        <= key_nxt;
    age_r        <= age_nxt;
    res_status_r <= res_status_nxt;
    res_age_r    <= res_age_nxt;
    res_pos_r    <= res_pos_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_age_r    <= res_age_r;
      out_pos_r    <= 4'(res_pos_r);
      out_count_r  <= 5'(count_r);
    end
  end

  // Record memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.found_age = out_age_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.count_now = out_count_r;

  // Checks
  `SRT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `SRT_ASSERT_SAME(a_load_from_done, clk, rst_n, $rose(out_valid_r),
                   $past(state_r) == srt_pkg::S_DONE)
  `SRT_ASSERT_SAME(a_no_write_idle, clk, rst_n, state_r == srt_pkg::S_IDLE, !wr_en)
  `SRT_ASSERT_NEXT(a_count_only_on_put, clk, rst_n,
                   rst_n && (state_r != srt_pkg::S_INS_PUT), $stable(count_r))

endmodule
